/* hdl/sctd_pkg.sv */
// Package with the shared constants, widths and item types of the sine/cosine series unit.
`timescale 1ns / 1ps
package sctd_pkg;

  // Default number of series terms after the first one.
  localparam int unsigned EXTRA_TERMS_DEF = 9;

  // Field widths.
  localparam int unsigned ANG_W = 26;
  localparam int unsigned VAL_W = 32;

  // Degrees to radians: pi in Q60, divided by 180 and rounded to Q40.
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_K64 = ((PI_Q60 / 64'd180) + (64'd1 << 19)) >> 20;
  localparam int unsigned K_W     = 35;
  localparam int unsigned KL_W    = 18;
  localparam logic [K_W-1:0] DEG_K = DEG_K64[K_W-1:0];

  // Internal magnitude widths, in Q32 where they hold a real value, but for the reciprocals in Q50.
  localparam int unsigned X_W   = 36;
  localparam int unsigned XS_W  = 18;
  localparam int unsigned X2_W  = 40;
  localparam int unsigned XH_W  = 20;
  localparam int unsigned T_W   = 44;
  localparam int unsigned TH_W  = 22;
  localparam int unsigned PR_W  = T_W + X2_W;
  localparam int unsigned N_W   = 50;
  localparam int unsigned NH_W  = 25;
  localparam int unsigned RC_S  = 50;
  localparam int unsigned RC_W  = 50;
  localparam int unsigned RH_W  = 25;
  localparam int unsigned Q0_W  = 48;
  localparam int unsigned D_W   = 10;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned FRAC  = 32;

  // One item in flight between the series steps.
  typedef struct packed {
    logic [T_W-1:0]          t;
    logic signed [SUM_W-1:0] sum;
    logic                    sub;
    logic [X2_W-1:0]         x2;
    logic                    cos;
    logic                    neg;
  } sctd_item_t;

  // Fields carried unchanged through a step.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
    logic                    cos;
    logic                    neg;
  } sctd_pass_t;

endpackage

/* hdl/sine_cosine_taylor_degrees_top.sv */
// Top level of the pipelined Taylor-series sine and cosine of an angle in degrees.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid_i / in_ready_o    | command_i (1 bit), angle_deg_i (s26)
//   output  | out_valid_o / out_ready_i  | value_o (s32, Q2.30)
//
// One item enters each cycle while no stage is held by a stalled output.
// Every series step has six stages; its depth is set by the split 44 x 40 bit product
// and the reciprocal division that follow each other in each step.
// Reset clears only the valid bits of the stages. Each stage holds while the next one is
// full and stalled, so a bubble anywhere lets a new item in while a result waits.
`timescale 1ns / 1ps
module sine_cosine_taylor_degrees_top #(
  parameter int unsigned EXTRA_TERMS = sctd_pkg::EXTRA_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [sctd_pkg::ANG_W-1:0] angle_deg_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sctd_pkg::VAL_W-1:0] value_o
);
  import sctd_pkg::*;

  localparam int unsigned MLO_W = ANG_W + KL_W;
  localparam int unsigned MHI_W = ANG_W + K_W - KL_W;
  localparam int unsigned XP_W  = ANG_W + K_W;
  localparam int unsigned SQ_W  = 2 * X_W;
  localparam int unsigned QS_W  = SUM_W - 2;

  // Front stages f1..f5, back stages a, b, c.
  logic v_f1_q, v_f2_q, v_f3_q, v_f4_q, v_f5_q, v_a_q, v_b_q, v_c_q;
  logic en_f1, en_f2, en_f3, en_f4, en_f5, en_a, en_b, en_c;

  logic [EXTRA_TERMS:0] cv;
  logic [EXTRA_TERMS:0] cr;
  sctd_item_t           ci [EXTRA_TERMS+1];

  logic [ANG_W-1:0]        mag1_q;
  logic                    cos1_q, neg1_q, cos2_q, neg2_q, cos3_q, neg3_q;
  logic                    cos4_q, neg4_q, cos5_q, neg5_q;
  logic [MLO_W-1:0]        plo2_q;
  logic [MHI_W-1:0]        phi2_q;
  logic [XP_W-1:0]         xp3;
  logic [X_W-1:0]          x3_q, x4_q, x5_q;
  logic [2*XS_W-1:0]       hh4_q, hl4_q, ll4_q;
  logic [SQ_W-1:0]         sq5;
  logic [X2_W-1:0]         x2_5_q;
  logic signed [SUM_W-1:0] sa_q, sb_q;
  logic                    cos_a_q, neg_a_q;
  logic signed [QS_W-1:0]  qs;
  logic signed [VAL_W-1:0] val_d, val_q;

  // Stage enables from the output back to the input.
  assign en_c  = !v_c_q  || out_ready_i;
  assign en_b  = !v_b_q  || en_c;
  assign en_a  = !v_a_q  || en_b;
  assign en_f5 = !v_f5_q || cr[0];
  assign en_f4 = !v_f4_q || en_f5;
  assign en_f3 = !v_f3_q || en_f4;
  assign en_f2 = !v_f2_q || en_f3;
  assign en_f1 = !v_f1_q || en_f2;
  assign cr[EXTRA_TERMS] = en_a;
  assign in_ready_o = en_f1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f1_q <= 1'b0;
      v_f2_q <= 1'b0;
      v_f3_q <= 1'b0;
      v_f4_q <= 1'b0;
      v_f5_q <= 1'b0;
      v_a_q  <= 1'b0;
      v_b_q  <= 1'b0;
      v_c_q  <= 1'b0;
    end else begin
      if (en_f1) v_f1_q <= in_valid_i;
      if (en_f2) v_f2_q <= v_f1_q;
      if (en_f3) v_f3_q <= v_f2_q;
      if (en_f4) v_f4_q <= v_f3_q;
      if (en_f5) v_f5_q <= v_f4_q;
      if (en_a)  v_a_q  <= cv[EXTRA_TERMS];
      if (en_b)  v_b_q  <= v_a_q;
      if (en_c)  v_c_q  <= v_b_q;
    end
  end

  // Stage f1: magnitude of the angle.
  always_ff @(posedge clk_i) begin
    if (en_f1) begin
      mag1_q <= angle_deg_i[ANG_W-1] ? (ANG_W'(0) - angle_deg_i) : angle_deg_i;
      cos1_q <= command_i;
      neg1_q <= angle_deg_i[ANG_W-1];
    end
  end

  // Stage f2: partial products of the magnitude by pi/180.
  always_ff @(posedge clk_i) begin
    if (en_f2) begin
      plo2_q <= MLO_W'(mag1_q * DEG_K[KL_W-1:0]);
      phi2_q <= MHI_W'(mag1_q * DEG_K[K_W-1:KL_W]);
      cos2_q <= cos1_q;
      neg2_q <= neg1_q;
    end
  end

  // Stage f3: radians in Q32, rounded half up.
  assign xp3 = XP_W'(plo2_q) + (XP_W'(phi2_q) << KL_W) + (XP_W'(1) << 23);

  always_ff @(posedge clk_i) begin
    if (en_f3) begin
      x3_q   <= xp3[24 +: X_W];
      cos3_q <= cos2_q;
      neg3_q <= neg2_q;
    end
  end

  // Stage f4: partial products of x squared.
  always_ff @(posedge clk_i) begin
    if (en_f4) begin
      hh4_q  <= x3_q[X_W-1:XS_W] * x3_q[X_W-1:XS_W];
      hl4_q  <= x3_q[X_W-1:XS_W] * x3_q[XS_W-1:0];
      ll4_q  <= x3_q[XS_W-1:0] * x3_q[XS_W-1:0];
      x4_q   <= x3_q;
      cos4_q <= cos3_q;
      neg4_q <= neg3_q;
    end
  end

  // Stage f5: x squared in Q32.
  assign sq5 = (SQ_W'(hh4_q) << (2 * XS_W)) + (SQ_W'(hl4_q) << (XS_W + 1)) + SQ_W'(ll4_q);

  always_ff @(posedge clk_i) begin
    if (en_f5) begin
      x2_5_q <= sq5[FRAC +: X2_W];
      x5_q   <= x4_q;
      cos5_q <= cos4_q;
      neg5_q <= neg4_q;
    end
  end

  // First term: one for cosine, x for sine, still to be added.
  assign cv[0]     = v_f5_q;
  assign ci[0].t   = cos5_q ? (T_W'(1) << FRAC) : T_W'(x5_q);
  assign ci[0].sum = '0;
  assign ci[0].sub = 1'b0;
  assign ci[0].x2  = x2_5_q;
  assign ci[0].cos = cos5_q;
  assign ci[0].neg = neg5_q;

  // Chain of series steps.
  for (genvar k = 0; k < EXTRA_TERMS; k++) begin : g_term
    sctd_term #(
      .STEP(k + 1)
    ) u_term (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (cv[k]),
      .in_ready_o (cr[k]),
      .in_item_i  (ci[k]),
      .out_valid_o(cv[k+1]),
      .out_ready_i(cr[k+1]),
      .out_item_o (ci[k+1])
    );
  end

  // Stage a: add the last term.
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      if (ci[EXTRA_TERMS].sub) begin
        sa_q <= ci[EXTRA_TERMS].sum - $signed({{(SUM_W-T_W){1'b0}}, ci[EXTRA_TERMS].t});
      end else begin
        sa_q <= ci[EXTRA_TERMS].sum + $signed({{(SUM_W-T_W){1'b0}}, ci[EXTRA_TERMS].t});
      end
      cos_a_q <= ci[EXTRA_TERMS].cos;
      neg_a_q <= ci[EXTRA_TERMS].neg;
    end
  end

  // Stage b: odd symmetry of sine.
  always_ff @(posedge clk_i) begin
    if (en_b) begin
      sb_q <= (!cos_a_q && neg_a_q) ? -sa_q : sa_q;
    end
  end

  // Stage c: Q32 to Q30 toward minus infinity, then saturate.
  assign qs = QS_W'(sb_q >>> 2);

  always_comb begin
    if (qs > QS_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      val_d = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (qs < QS_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
      val_d = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      val_d = qs[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      val_q <= val_d;
    end
  end

  assign out_valid_o = v_c_q;
  assign value_o     = val_q;

  // With the output free, every stage may move, so the input is open.
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input blocked while the output is free");

  // An accepted item lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_f1_q)
    else $error("accepted item missing from the first stage");

  // The last front stage keeps its item while the series chain is stalled.
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_f5_q && !cr[0]) |=> v_f5_q)
    else $error("item lost at the series chain entry");

endmodule

/* hdl/sctd_term.sv */
// One series step: fold the last term into the sum, multiply it by x squared and divide by the step's denominator.
`timescale 1ns / 1ps
module sctd_term #(
  parameter int unsigned STEP = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sctd_pkg::sctd_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sctd_pkg::sctd_item_t out_item_o
);
  import sctd_pkg::*;

  localparam int unsigned DSIN = (2 * STEP) * (2 * STEP + 1);
  localparam int unsigned DCOS = (2 * STEP - 1) * (2 * STEP);
  localparam logic [63:0] RC_ONE = 64'd1 << RC_S;
  localparam logic [63:0] MSIN64 = RC_ONE / 64'(DSIN);
  localparam logic [63:0] MCOS64 = RC_ONE / 64'(DCOS);
  localparam logic [RC_W-1:0] MSIN = MSIN64[RC_W-1:0];
  localparam logic [RC_W-1:0] MCOS = MCOS64[RC_W-1:0];
  localparam logic [D_W-1:0] DSIN_C = D_W'(DSIN);
  localparam logic [D_W-1:0] DCOS_C = D_W'(DCOS);

  logic [6:1] v_q;
  logic [6:1] en;

  logic [TH_W+XH_W-1:0] pp1_q [4];
  sctd_pass_t           p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic [N_W-1:0]       n2_q, n3_q, n4_q, n5_q;
  logic [2*NH_W-1:0]    pp3_q [4];
  logic [Q0_W-1:0]      q04_q, q05_q;
  logic [Q0_W+D_W-1:0]  prod5_q;
  logic [T_W-1:0]       q6_q;

  logic [PR_W-1:0]      prod2;
  logic [N_W+RC_W-1:0]  prod4;
  logic [RC_W-1:0]      m3;
  logic [D_W-1:0]       d5;
  logic [N_W-1:0]       r5;
  logic [Q0_W-1:0]      q6_d;
  sctd_pass_t           p1_d;

  // Stage enables: a stage moves when it is empty or the next one moves.
  always_comb begin
    en[6] = !v_q[6] || out_ready_i;
    for (int i = 5; i >= 1; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int i = 2; i <= 6; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // Stage 1: fold the pending term into the sum and form partial products.
  always_comb begin
    p1_d.x2  = in_item_i.x2;
    p1_d.cos = in_item_i.cos;
    p1_d.neg = in_item_i.neg;
    if (in_item_i.sub) begin
      p1_d.sum = in_item_i.sum - $signed({{(SUM_W-T_W){1'b0}}, in_item_i.t});
    end else begin
      p1_d.sum = in_item_i.sum + $signed({{(SUM_W-T_W){1'b0}}, in_item_i.t});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q     <= p1_d;
      pp1_q[0] <= (TH_W+XH_W)'(in_item_i.t[TH_W-1:0] * in_item_i.x2[XH_W-1:0]);
      pp1_q[1] <= (TH_W+XH_W)'(in_item_i.t[TH_W-1:0] * in_item_i.x2[X2_W-1:XH_W]);
      pp1_q[2] <= (TH_W+XH_W)'(in_item_i.t[T_W-1:TH_W] * in_item_i.x2[XH_W-1:0]);
      pp1_q[3] <= (TH_W+XH_W)'(in_item_i.t[T_W-1:TH_W] * in_item_i.x2[X2_W-1:XH_W]);
    end
  end

  // Stage 2: sum the partial products and drop the fraction of the product.
  assign prod2 = PR_W'(pp1_q[0])
               + (PR_W'(pp1_q[1]) << XH_W)
               + (PR_W'(pp1_q[2]) << TH_W)
               + (PR_W'(pp1_q[3]) << (TH_W + XH_W));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p2_q <= p1_q;
      n2_q <= prod2[FRAC +: N_W];
    end
  end

  // Stage 3: partial products of the quotient estimate by the reciprocal.
  assign m3 = p2_q.cos ? MCOS : MSIN;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q     <= p2_q;
      n3_q     <= n2_q;
      pp3_q[0] <= (2*NH_W)'(n2_q[NH_W-1:0] * m3[RH_W-1:0]);
      pp3_q[1] <= (2*NH_W)'(n2_q[NH_W-1:0] * m3[RC_W-1:RH_W]);
      pp3_q[2] <= (2*NH_W)'(n2_q[N_W-1:NH_W] * m3[RH_W-1:0]);
      pp3_q[3] <= (2*NH_W)'(n2_q[N_W-1:NH_W] * m3[RC_W-1:RH_W]);
    end
  end

  // Stage 4: the estimate is the exact quotient or one below it.
  assign prod4 = (N_W+RC_W)'(pp3_q[0])
               + ((N_W+RC_W)'(pp3_q[1]) << RH_W)
               + ((N_W+RC_W)'(pp3_q[2]) << NH_W)
               + ((N_W+RC_W)'(pp3_q[3]) << (NH_W + RH_W));

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p4_q  <= p3_q;
      n4_q  <= n3_q;
      q04_q <= prod4[RC_S +: Q0_W];
    end
  end

  // Stage 5: multiply the estimate back by the denominator.
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      p5_q    <= p4_q;
      n5_q    <= n4_q;
      q05_q   <= q04_q;
      prod5_q <= q04_q * (p4_q.cos ? DCOS_C : DSIN_C);
    end
  end

  // Stage 6: correct the estimate when the remainder reaches the denominator.
  assign d5   = p5_q.cos ? DCOS_C : DSIN_C;
  assign r5   = n5_q - prod5_q[N_W-1:0];
  assign q6_d = q05_q + Q0_W'(r5 >= N_W'(d5));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      p6_q <= p5_q;
      q6_q <= q6_d[T_W-1:0];
    end
  end

  assign out_valid_o    = v_q[6];
  assign out_item_o.t   = q6_q;
  assign out_item_o.sum = p6_q.sum;
  assign out_item_o.sub = (STEP % 2) == 1;
  assign out_item_o.x2  = p6_q.x2;
  assign out_item_o.cos = p6_q.cos;
  assign out_item_o.neg = p6_q.neg;

  // The reciprocal estimate is never more than one below the quotient.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (r5 < (N_W'(d5) << 1)))
    else $error("quotient estimate off by more than one");

  // A new term always fits the term width.
  a_term_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (q05_q[Q0_W-1:T_W] == '0))
    else $error("series term exceeds its width");

  // A loaded first stage keeps its item while the second stage is stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && !en[2]) |=> v_q[1])
    else $error("item lost in a stalled step");

endmodule

/* tb/tb.sv */
// Testbench for the sine and cosine series unit: random and directed angles checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import sctd_pkg::*;

  localparam int unsigned N_TERMS = EXTRA_TERMS_DEF;
  localparam int unsigned LATENCY = 8 + 6 * N_TERMS;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 1500;
  localparam logic CMD_SIN = 1'b0;
  localparam logic CMD_COS = 1'b1;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 26'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_MIN = -26'sd23592960;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic command;
  logic signed [ANG_W-1:0] angle_deg;
  logic out_valid;
  logic out_ready;
  logic signed [VAL_W-1:0] value;

  int unsigned error_count;
  int unsigned idle_cycles;
  bit stim_done;

  sine_cosine_taylor_degrees_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .command_i  (command),
    .angle_deg_i(angle_deg),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .value_o    (value)
  );

  // Prints one mismatch line and counts it.
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // floor(a * b / 2^32) on unsigned magnitudes.
  function automatic logic [63:0] mul_frac32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = a * b;
    return prod[95:32];
  endfunction

  // Truncated Taylor series for one angle, returned as saturated Q2.30.
  function automatic logic signed [VAL_W-1:0] series_value(input logic cmd,
                                                           input logic signed [ANG_W-1:0] ang);
    logic [63:0] deg_k;
    logic [63:0] mag;
    logic [63:0] rad;
    logic [63:0] rad2;
    logic [63:0] term;
    logic [63:0] den;
    longint sum;
    longint q30;
    deg_k = ((64'h3243F6A8885A308D / 64'd180) + (64'd1 << 19)) >> 20;
    // The magnitude is formed at full width so that the most negative angle stays exact.
    mag = (ang < 0) ? (64'd0 - 64'(ang)) : 64'(ang);
    rad = (mag * deg_k + (64'd1 << 23)) >> 24;
    rad2 = mul_frac32(rad, rad);
    term = (cmd == CMD_COS) ? (64'd1 << 32) : rad;
    sum = longint'(term);
    for (int k = 1; k <= N_TERMS; k++) begin
      den = (cmd == CMD_COS) ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = mul_frac32(term, rad2) / den;
      if (k % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (cmd == CMD_SIN && ang < 0) begin
      sum = -sum;
    end
    // Q32 to Q30 rounding toward minus infinity.
    q30 = sum >>> 2;
    if (q30 > 64'sd2147483647) q30 = 64'sd2147483647;
    if (q30 < -64'sd2147483648) q30 = -64'sd2147483648;
    return q30[VAL_W-1:0];
  endfunction

  // Holds the expected values in order of acceptance.
  class value_scoreboard;
    logic signed [VAL_W-1:0] pending_values[$];

    function void note_angle(input logic cmd, input logic signed [ANG_W-1:0] ang);
      pending_values.push_back(series_value(cmd, ang));
    endfunction

    task check_value(input logic signed [VAL_W-1:0] got);
      logic signed [VAL_W-1:0] want;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected value %0d", got));
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
        report($sformatf("value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  value_scoreboard value_sb = new();

  // Half with no gap, most of the others short, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sends one item and waits for its acceptance.
  task automatic send_angle(input logic cmd, input logic signed [ANG_W-1:0] ang);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return ANG_MIN + ANG_W'($urandom_range(0, 47185920));
    if (r < 8) return ANG_W'($urandom_range(0, 2 ** 20)) - 26'sd524288;
    return ANG_W'($urandom);
  endfunction

  // Stimulus: directed extremes, then random angles.
  initial begin
    logic signed [ANG_W-1:0] directed[$];
    in_valid = 1'b0;
    command = CMD_SIN;
    angle_deg = '0;
    stim_done = 1'b0;
    directed = '{26'sd0, 26'sd1, -26'sd1, ANG_MAX, ANG_MIN, 26'sd5898240, -26'sd5898240,
                 26'sd11796480, 26'sd33554431, -26'sd33554431 - 26'sd1};
    wait (rst_n);
    @(negedge clk);
    foreach (directed[i]) begin
      send_angle(CMD_SIN, directed[i]);
      send_angle(CMD_COS, directed[i]);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // Drain the pipeline before continuing.
        in_valid <= 1'b0;
        wait (value_sb.pending_values.size() == 0);
        @(negedge clk);
      end
      send_angle(logic'($urandom_range(0, 1)), rand_angle());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Note accepted items and check results at the rising edge.
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_sb.note_angle(command, angle_deg);
    end
    if (out_valid && out_ready) begin
      value_sb.check_value(value);
    end
  end

  // Receiver stalls.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any acceptance.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // End of run.
  initial begin
    error_count = 0;
    wait (stim_done);
    wait (value_sb.pending_values.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && value_sb.pending_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
